// File: src/ecs_pkg.sv
// Shared constants, codes, descriptor row type and a swap-remove helper for the entity-component table.
`timescale 1ns / 1ps
package ecs_pkg;
    localparam int NUM_SLOTS  = 256;
    localparam int SLOT_BITS  = 8;
    localparam int NUM_KINDS  = 16;
    localparam int KIND_BITS  = 4;
    localparam int POS_BITS   = 5;
    localparam int CNT_BITS   = 9;
    localparam int GEN_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int REQ_BITS   = 3;
    localparam int STAT_BITS  = 3;
    localparam int CFG_BITS   = 5;
    localparam int KSLOT_BITS = KIND_BITS + SLOT_BITS;
    localparam logic [CFG_BITS-1:0] KINDS_RESET = CFG_BITS'(NUM_KINDS);

    // Request codes
    localparam logic [REQ_BITS-1:0] REQ_CREATE  = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_DESTROY = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_ATTACH  = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_DETACH  = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_QUERY   = 3'd4;

    // Status codes
    localparam logic [STAT_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_STALE    = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_PRESENCE = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_BAD_KIND = 3'd4;

    // One descriptor row: owner, kind count, kind->position (0 absent), position->kind
    typedef struct packed {
        logic [SLOT_BITS-1:0]                 owner;
        logic [POS_BITS-1:0]                  count;
        logic [NUM_KINDS-1:0][POS_BITS-1:0]   k2p;
        logic [NUM_KINDS-1:0][KIND_BITS-1:0]  p2k;
    } desc_t;

    localparam int DESC_BITS = $bits(desc_t);

    // Swap-remove one kind from a descriptor row
    function automatic desc_t desc_detach(input desc_t row, input logic [KIND_BITS-1:0] kind);
        desc_t                r;
        logic [POS_BITS-1:0]  p1;
        logic [POS_BITS-1:0]  last;
        logic [KIND_BITS-1:0] lk;
        r    = row;
        p1   = row.k2p[kind] - POS_BITS'(1);
        last = row.count - POS_BITS'(1);
        lk   = row.p2k[last[KIND_BITS-1:0]];
        r.p2k[p1[KIND_BITS-1:0]] = lk;
        r.k2p[lk]   = POS_BITS'(p1[KIND_BITS-1:0]) + POS_BITS'(1);
        r.k2p[kind] = '0;
        r.count     = last;
        return r;
    endfunction
endpackage

// File: src/entity_component_sparse_set_table_unit.sv
// Top level of the entity-component table with generational handles.
`timescale 1ns / 1ps
// One request word in, one result word out. Requests are handled one at a time;
// the state lives in synchronous RAMs (generations, slot->descriptor, free stack,
// descriptor rows, and per-kind packed arrays) and each request is a short chain of
// read-then-write steps through them. After the lookup step a full table or a bad request
// finishes at once; create writes the new slot's entries, attach reads and writes the
// descriptor row, query and detach read the descriptor row and then the per-kind arrays
// (both finish early when the kind is absent), and destroy does a detach per attached
// component (each component detach is a read and a write of the per-kind arrays) and
// then moves the last descriptor row into the freed one. s_ready returns on the edge that
// raises m_valid; a result stalled on the output holds the following request in its last
// step until the waiting word is taken. No clearing pass is needed after reset:
// generations of never-used slots read as zero through the fresh-slot pointer.
module entity_component_sparse_set_table_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ecs_pkg::CFG_BITS-1:0]    cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ecs_pkg::REQ_BITS-1:0]    s_req_type,
    input  logic [ecs_pkg::SLOT_BITS-1:0]   s_entity_id,
    input  logic [ecs_pkg::GEN_BITS-1:0]    s_entity_gen,
    input  logic [ecs_pkg::KIND_BITS-1:0]   s_component_kind,
    input  logic [ecs_pkg::VALUE_BITS-1:0]  s_component_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ecs_pkg::STAT_BITS-1:0]   m_status,
    output logic [ecs_pkg::SLOT_BITS-1:0]   m_result_id,
    output logic [ecs_pkg::GEN_BITS-1:0]    m_result_gen,
    output logic                            m_present,
    output logic [ecs_pkg::VALUE_BITS-1:0]  m_read_value
);
    import ecs_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_LOOK  = 11'b00000000010,
        S_CRT   = 11'b00000000100,
        S_DESC  = 11'b00000001000,
        S_DT_RD = 11'b00000010000,
        S_DT_WR = 11'b00000100000,
        S_DS_CP = 11'b00001000000,
        S_DS_WR = 11'b00010000000,
        S_QRY   = 11'b00100000000,
        S_QVAL  = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } state_t;

    state_t state_reg;

    logic [CFG_BITS-1:0]   kinds_reg;
    logic [CNT_BITS-1:0]   free_cnt_reg, fresh_reg, live_cnt_reg;
    logic [NUM_SLOTS-1:0]  live_bits_reg;
    logic [NUM_KINDS-1:0][CNT_BITS-1:0] kcount_reg;

    logic [REQ_BITS-1:0]   req_reg;
    logic [SLOT_BITS-1:0]  id_reg, slot_reg, d_reg;
    logic [GEN_BITS-1:0]   gen_in_reg;
    logic [KIND_BITS-1:0]  kind_reg, cur_kind_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  from_fresh_reg;
    desc_t                 desc_reg;

    logic [STAT_BITS-1:0]  res_status_reg;
    logic [SLOT_BITS-1:0]  res_id_reg;
    logic [GEN_BITS-1:0]   res_gen_reg;
    logic                  res_present_reg;
    logic [VALUE_BITS-1:0] res_val_reg;
    logic                  m_valid_reg;

    // RAM ports
    logic                  gen_we, s2d_we, stk_we, desc_we, s2p_we, p2s_we, val_we;
    logic [SLOT_BITS-1:0]  gen_wa, gen_ra, s2d_wa, s2d_ra, stk_wa, stk_ra, desc_wa, desc_ra;
    logic [GEN_BITS-1:0]   gen_wd, gen_q;
    logic [SLOT_BITS-1:0]  s2d_wd, s2d_q, stk_wd, stk_q;
    desc_t                 desc_wd, desc_q;
    logic [KSLOT_BITS-1:0] s2p_wa, s2p_ra, p2s_wa, p2s_ra, val_wa, val_ra;
    logic [SLOT_BITS-1:0]  s2p_wd, s2p_q, p2s_wd, p2s_q;
    logic [VALUE_BITS-1:0] val_wd, val_q;

    ecs_ram #(.WIDTH(GEN_BITS), .DEPTH(NUM_SLOTS)) u_gen (
        .aclk, .we(gen_we), .waddr(gen_wa), .wdata(gen_wd), .raddr(gen_ra), .rdata(gen_q));
    ecs_ram #(.WIDTH(SLOT_BITS), .DEPTH(NUM_SLOTS)) u_s2d (
        .aclk, .we(s2d_we), .waddr(s2d_wa), .wdata(s2d_wd), .raddr(s2d_ra), .rdata(s2d_q));
    ecs_ram #(.WIDTH(SLOT_BITS), .DEPTH(NUM_SLOTS)) u_stk (
        .aclk, .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_q));
    ecs_ram #(.WIDTH(DESC_BITS), .DEPTH(NUM_SLOTS)) u_desc (
        .aclk, .we(desc_we), .waddr(desc_wa), .wdata(desc_wd), .raddr(desc_ra),
        .rdata(desc_q));
    ecs_ram #(.WIDTH(SLOT_BITS), .DEPTH(NUM_SLOTS * NUM_KINDS)) u_s2p (
        .aclk, .we(s2p_we), .waddr(s2p_wa), .wdata(s2p_wd), .raddr(s2p_ra), .rdata(s2p_q));
    ecs_ram #(.WIDTH(SLOT_BITS), .DEPTH(NUM_SLOTS * NUM_KINDS)) u_p2s (
        .aclk, .we(p2s_we), .waddr(p2s_wa), .wdata(p2s_wd), .raddr(p2s_ra), .rdata(p2s_q));
    ecs_ram #(.WIDTH(VALUE_BITS), .DEPTH(NUM_SLOTS * NUM_KINDS)) u_val (
        .aclk, .we(val_we), .waddr(val_wa), .wdata(val_wd), .raddr(val_ra), .rdata(val_q));

    // Decode helpers
    logic                 s_acc, m_free;
    logic [CNT_BITS-1:0]  free_top, live_last, lp_full, attach_pk;
    logic [SLOT_BITS-1:0] lp, new_slot;
    logic [GEN_BITS-1:0]  gen_eff, new_gen;
    logic                 handle_ok, full, kind_ok, has, do_move;
    desc_t                fresh_desc, attach_desc, det_desc;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign m_free    = !m_valid_reg || m_ready;
    assign free_top  = free_cnt_reg - CNT_BITS'(1);
    assign live_last = live_cnt_reg - CNT_BITS'(1);
    assign lp_full   = kcount_reg[cur_kind_reg] - CNT_BITS'(1);
    assign lp        = lp_full[SLOT_BITS-1:0];
    assign attach_pk = kcount_reg[kind_reg];
    assign gen_eff   = ({1'b0, id_reg} < fresh_reg) ? gen_q : '0;
    assign handle_ok = live_bits_reg[id_reg] && (gen_eff == gen_in_reg);
    assign full      = (live_cnt_reg == CNT_BITS'(NUM_SLOTS)) ||
                       ((free_cnt_reg == '0) && (fresh_reg == CNT_BITS'(NUM_SLOTS)));
    assign new_slot  = (free_cnt_reg != '0) ? stk_q : fresh_reg[SLOT_BITS-1:0];
    assign kind_ok   = ({1'b0, kind_reg} < kinds_reg);
    assign has       = (desc_q.k2p[kind_reg] != '0);
    assign new_gen   = (from_fresh_reg ? GEN_BITS'(0) : gen_q) + GEN_BITS'(1);
    assign do_move   = (lp != s2p_q);
    assign det_desc  = desc_detach(desc_reg, cur_kind_reg);

    // Build new and attached descriptor rows
    always_comb begin
        fresh_desc       = '0;
        fresh_desc.owner = slot_reg;
        attach_desc      = desc_q;
        attach_desc.k2p[kind_reg] = desc_q.count + POS_BITS'(1);
        attach_desc.p2k[desc_q.count[KIND_BITS-1:0]] = kind_reg;
        attach_desc.count = desc_q.count + POS_BITS'(1);
    end

    // Drive RAM ports per step
    always_comb begin
        gen_we = 1'b0; gen_wa = slot_reg; gen_wd = new_gen; gen_ra = id_reg;
        s2d_we = 1'b0; s2d_wa = slot_reg; s2d_wd = live_cnt_reg[SLOT_BITS-1:0];
        s2d_ra = id_reg;
        stk_we = 1'b0; stk_wa = free_cnt_reg[SLOT_BITS-1:0]; stk_wd = id_reg;
        stk_ra = free_top[SLOT_BITS-1:0];
        desc_we = 1'b0; desc_wa = d_reg; desc_wd = det_desc; desc_ra = d_reg;
        s2p_we = 1'b0; s2p_wa = {cur_kind_reg, p2s_q}; s2p_wd = s2p_q;
        s2p_ra = {cur_kind_reg, id_reg};
        p2s_we = 1'b0; p2s_wa = {cur_kind_reg, s2p_q}; p2s_wd = p2s_q;
        p2s_ra = {cur_kind_reg, lp};
        val_we = 1'b0; val_wa = {cur_kind_reg, s2p_q}; val_wd = val_q;
        val_ra = {cur_kind_reg, lp};
        case (state_reg)
            S_IDLE: begin
                gen_ra = s_entity_id;
                s2d_ra = s_entity_id;
            end
            S_LOOK: begin
                gen_ra  = new_slot;
                desc_ra = s2d_q;
            end
            S_CRT: begin
                gen_we  = 1'b1;
                s2d_we  = 1'b1;
                desc_we = 1'b1;
                desc_wa = live_cnt_reg[SLOT_BITS-1:0];
                desc_wd = fresh_desc;
            end
            S_DESC: begin
                s2p_ra = {kind_reg, id_reg};
                if (req_reg == REQ_ATTACH && !has) begin
                    desc_we = 1'b1;
                    desc_wd = attach_desc;
                    s2p_we  = 1'b1;
                    s2p_wa  = {kind_reg, id_reg};
                    s2p_wd  = attach_pk[SLOT_BITS-1:0];
                    p2s_we  = 1'b1;
                    p2s_wa  = {kind_reg, attach_pk[SLOT_BITS-1:0]};
                    p2s_wd  = id_reg;
                    val_we  = 1'b1;
                    val_wa  = {kind_reg, attach_pk[SLOT_BITS-1:0]};
                    val_wd  = val_reg;
                end
            end
            S_DT_WR: begin
                // Move the last packed entry into the hole
                s2p_we = do_move;
                p2s_we = do_move;
                val_we = do_move;
                desc_we = (req_reg == REQ_DETACH);
            end
            S_DS_CP: begin
                desc_ra = live_last[SLOT_BITS-1:0];
            end
            S_DS_WR: begin
                desc_we = (d_reg != live_last[SLOT_BITS-1:0]);
                desc_wd = desc_q;
                s2d_we  = desc_we;
                s2d_wa  = desc_q.owner;
                s2d_wd  = d_reg;
                stk_we  = 1'b1;
            end
            S_QRY: begin
                val_ra = {kind_reg, s2p_q};
            end
            default: begin
            end
        endcase
    end

    // Sequencer and bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            kinds_reg     <= KINDS_RESET;
            free_cnt_reg  <= '0;
            fresh_reg     <= '0;
            live_cnt_reg  <= '0;
            live_bits_reg <= '0;
            kcount_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                kinds_reg <= cfg_wdata;
            end
            // Raise valid as a result word is loaded, drop it once taken
            if (state_reg == S_FIN && m_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        req_reg    <= s_req_type;
                        id_reg     <= s_entity_id;
                        gen_in_reg <= s_entity_gen;
                        kind_reg   <= s_component_kind;
                        val_reg    <= s_component_value;
                        state_reg  <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    res_id_reg      <= id_reg;
                    res_gen_reg     <= gen_eff;
                    res_present_reg <= 1'b0;
                    res_val_reg     <= '0;
                    d_reg           <= s2d_q;
                    cur_kind_reg    <= kind_reg;
                    if (req_reg == REQ_CREATE) begin
                        if (full) begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_FIN;
                        end else begin
                            res_status_reg <= ST_OK;
                            slot_reg       <= new_slot;
                            from_fresh_reg <= (free_cnt_reg == '0);
                            if (free_cnt_reg != '0) begin
                                free_cnt_reg <= free_top;
                            end else begin
                                fresh_reg <= fresh_reg + CNT_BITS'(1);
                            end
                            state_reg <= S_CRT;
                        end
                    end else if (req_reg > REQ_QUERY) begin
                        res_status_reg <= ST_BAD_KIND;
                        state_reg      <= S_FIN;
                    end else if (!handle_ok) begin
                        res_status_reg <= ST_STALE;
                        state_reg      <= S_FIN;
                    end else if (req_reg != REQ_DESTROY && !kind_ok) begin
                        res_status_reg <= ST_BAD_KIND;
                        state_reg      <= S_FIN;
                    end else begin
                        res_status_reg <= ST_OK;
                        state_reg      <= S_DESC;
                    end
                end
                S_CRT: begin
                    live_bits_reg[slot_reg] <= 1'b1;
                    live_cnt_reg <= live_cnt_reg + CNT_BITS'(1);
                    res_id_reg   <= slot_reg;
                    res_gen_reg  <= new_gen;
                    state_reg    <= S_FIN;
                end
                S_DESC: begin
                    desc_reg <= desc_q;
                    case (req_reg)
                        REQ_DESTROY: begin
                            cur_kind_reg <= desc_q.p2k[0];
                            state_reg    <= (desc_q.count == '0) ? S_DS_CP : S_DT_RD;
                        end
                        REQ_ATTACH: begin
                            if (has) begin
                                res_status_reg <= ST_PRESENCE;
                            end else begin
                                kcount_reg[kind_reg] <= attach_pk + CNT_BITS'(1);
                            end
                            state_reg <= S_FIN;
                        end
                        REQ_DETACH: begin
                            if (has) begin
                                state_reg <= S_DT_RD;
                            end else begin
                                res_status_reg <= ST_PRESENCE;
                                state_reg      <= S_FIN;
                            end
                        end
                        default: begin
                            state_reg <= has ? S_QRY : S_FIN;
                        end
                    endcase
                end
                S_DT_RD: begin
                    state_reg <= S_DT_WR;
                end
                S_DT_WR: begin
                    kcount_reg[cur_kind_reg] <= lp_full;
                    desc_reg <= det_desc;
                    if (req_reg == REQ_DETACH) begin
                        state_reg <= S_FIN;
                    end else if (det_desc.count == '0) begin
                        state_reg <= S_DS_CP;
                    end else begin
                        cur_kind_reg <= det_desc.p2k[0];
                        state_reg    <= S_DT_RD;
                    end
                end
                S_DS_CP: begin
                    state_reg <= S_DS_WR;
                end
                S_DS_WR: begin
                    live_bits_reg[id_reg] <= 1'b0;
                    free_cnt_reg <= free_cnt_reg + CNT_BITS'(1);
                    live_cnt_reg <= live_last;
                    state_reg    <= S_FIN;
                end
                S_QRY: begin
                    state_reg <= S_QVAL;
                end
                S_QVAL: begin
                    res_present_reg <= 1'b1;
                    res_val_reg     <= val_q;
                    state_reg       <= S_FIN;
                end
                S_FIN: begin
                    if (m_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN && m_free) begin
            m_status     <= res_status_reg;
            m_result_id  <= res_id_reg;
            m_result_gen <= res_gen_reg;
            m_present    <= res_present_reg;
            m_read_value <= res_val_reg;
        end
    end

    assign m_valid = m_valid_reg;
endmodule

// File: src/ecs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ecs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write when enabled, read every cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/ecs_checker.sv
// Port-level checks for the entity-component table, bound to the top level.
`timescale 1ns / 1ps
module ecs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [ecs_pkg::STAT_BITS-1:0]  m_status,
    input logic                           m_present,
    input logic [ecs_pkg::VALUE_BITS-1:0] m_read_value
);
    import ecs_pkg::*;

    // One request in flight: no word taken right after another
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while one is in progress");

    // Valid and status hold until the result word is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result word dropped or changed while stalled");

    // Presence only on a good status
    a_present_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_present |-> m_status == ST_OK)
        else $error("present set with a failing status");

    // Value is zero unless present
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_present |-> m_read_value == '0)
        else $error("read value without presence");
endmodule

bind entity_component_sparse_set_table_unit ecs_checker u_ecs_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_status, .m_present, .m_read_value);
